FILE: hdl/bfd_pkg.sv
// shared constants, register indexes and queue item type for the box filter downscaler
package bfd_pkg;

    localparam int MAX_SIDE = 4096;
    localparam int SIDE_W   = 13;
    localparam int COL_W    = 12;
    localparam int K_W      = 4;
    localparam int N_W      = 25;
    localparam int ACC_W    = 32;
    localparam int CFG_W    = 13;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;
    localparam logic [IDX_W-1:0] REG_SIZE_LIMIT    = 2'd3;

    typedef struct packed {
        logic [COL_W-1:0] x;
        logic             first;
        logic             emit;
        logic             last;
        logic [N_W-1:0]   n;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic [7:0]       a;
    } item_t;

endpackage

FILE: hdl/bfd_fifo.sv
// two-entry queue between the front and back parts
module bfd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bfd_pkg::item_t wr_item,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output bfd_pkg::item_t rd_item
);

    bfd_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hdl/bfd_front.sv
// front part: configuration, raster position, factor choice and pixel classification
module bfd_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bfd_pkg::IDX_W-1:0]     cfg_index,
    input  logic [bfd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    chan_a,
    input  logic [7:0]                    chan_b,
    input  logic [7:0]                    chan_c,
    input  logic [7:0]                    chan_d,
    input  logic                          full,
    output logic                          push,
    output bfd_pkg::item_t                item
);

    logic [12:0] src_width_reg;
    logic [12:0] src_height_reg;
    logic [2:0]  chan_count_reg;
    logic [12:0] size_limit_reg;
    logic [11:0] col_reg;
    logic [11:0] row_reg;
    logic [3:0]  k_reg;

    logic        accept;
    logic        at_start;
    logic [12:0] w;
    logic [12:0] h;
    logic [3:0]  k_pick;
    logic [3:0]  k;
    logic [12:0] f;
    logic [12:0] ow_raw;
    logic [12:0] oh_raw;
    logic [12:0] ow;
    logic [12:0] oh;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] dx;
    logic [11:0] dy;
    logic [12:0] cx;
    logic [12:0] cy;
    logic [12:0] x_last;
    logic [12:0] y_last;
    logic [25:0] prod;
    logic        covered;
    logic [12:0] col_inc;
    logic [12:0] row_inc;

    assign at_start = (col_reg == 12'd0) && (row_reg == 12'd0);
    assign in_stall = full;
    assign accept   = in_valid && !full;

    // zero acts as one, oversize saturates
    always_comb
    begin
        w = src_width_reg;
        if (src_width_reg == 13'd0)
        begin
            w = 13'd1;
        end
        else if (src_width_reg > 13'(bfd_pkg::MAX_SIDE))
        begin
            w = 13'(bfd_pkg::MAX_SIDE);
        end
        h = src_height_reg;
        if (src_height_reg == 13'd0)
        begin
            h = 13'd1;
        end
        else if (src_height_reg > 13'(bfd_pkg::MAX_SIDE))
        begin
            h = 13'(bfd_pkg::MAX_SIDE);
        end
    end

    // smallest shift that brings both sides within the limit; a zero limit picks no shift
    always_comb
    begin
        k_pick = 4'd12;
        for (int i = 12; i >= 0; i--)
        begin
            if ((size_limit_reg == 13'd0) ||
                (((w >> i) <= size_limit_reg) && ((h >> i) <= size_limit_reg)))
            begin
                k_pick = 4'(i);
            end
        end
    end

    always_comb
    begin
        k       = at_start ? k_pick : k_reg;
        f       = 13'd1 << k;
        ow_raw  = w >> k;
        oh_raw  = h >> k;
        ow      = (ow_raw == 13'd0) ? 13'd1 : ow_raw;
        oh      = (oh_raw == 13'd0) ? 13'd1 : oh_raw;
        x       = col_reg >> k;
        y       = row_reg >> k;
        dx      = col_reg & f[11:0] - 12'd1;
        dy      = row_reg & f[11:0] - 12'd1;
        cx      = (w < f) ? w : f;
        cy      = (h < f) ? h : f;
        x_last  = (13'({1'b0, x}) << k) + cx - 13'd1;
        y_last  = (13'({1'b0, y}) << k) + cy - 13'd1;
        prod    = cx * cy;
        covered = ({1'b0, x} < ow) && ({1'b0, y} < oh);
        col_inc = {1'b0, col_reg} + 13'd1;
        row_inc = {1'b0, row_reg} + 13'd1;
    end

    always_comb
    begin
        item.x     = x;
        item.first = (dx == 12'd0) && (dy == 12'd0);
        item.emit  = ({1'b0, col_reg} == x_last) && ({1'b0, row_reg} == y_last);
        item.last  = ({1'b0, x} == ow - 13'd1) && ({1'b0, y} == oh - 13'd1);
        item.n     = prod[24:0];
        item.r     = chan_a;
        if (chan_count_reg >= 3'd3)
        begin
            item.g = chan_b;
            item.b = chan_c;
        end
        else
        begin
            item.g = chan_a;
            item.b = chan_a;
        end
        item.a = (chan_count_reg == 3'd4) ? chan_d : 8'd255;
    end

    assign push = accept && covered;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 13'd1;
            src_height_reg <= 13'd1;
            chan_count_reg <= 3'd4;
            size_limit_reg <= 13'd0;
            col_reg        <= 12'd0;
            row_reg        <= 12'd0;
            k_reg          <= 4'd0;
        end
        else
        begin
            // writes mid-image are dropped
            if (cfg_write && at_start)
            begin
                case (cfg_index)
                    bfd_pkg::REG_SOURCE_WIDTH:  src_width_reg  <= cfg_data;
                    bfd_pkg::REG_SOURCE_HEIGHT: src_height_reg <= cfg_data;
                    bfd_pkg::REG_CHANNEL_COUNT: chan_count_reg <= cfg_data[2:0];
                    bfd_pkg::REG_SIZE_LIMIT:    size_limit_reg <= cfg_data;
                    default:                    ;
                endcase
            end
            if (accept)
            begin
                if (at_start)
                begin
                    k_reg <= k_pick;
                end
                if (col_inc >= w)
                begin
                    col_reg <= 12'd0;
                    row_reg <= (row_inc >= h) ? 12'd0 : row_inc[11:0];
                end
                else
                begin
                    col_reg <= col_inc[11:0];
                end
            end
        end
    end

endmodule

FILE: hdl/bfd_back.sv
// back part: column accumulators, restoring divide and output register
module bfd_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           not_empty,
    input  bfd_pkg::item_t rd_item,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [7:0]     red,
    output logic [7:0]     green,
    output logic [7:0]     blue,
    output logic [7:0]     alpha,
    output logic           last_pixel
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [127:0]   acc_mem [bfd_pkg::MAX_SIDE];
    logic [127:0]   rd_data_reg;
    bfd_pkg::item_t cur_reg;
    logic [1:0]     state_reg;
    logic [2:0]     step_reg;
    logic [31:0]    rem_reg [4];
    logic [7:0]     quo_reg [4];
    logic [31:0]    dvs_reg;

    logic [31:0]    sum [4];
    logic [7:0]     pix [4];

    assign pop = (state_reg == ST_IDLE) && not_empty;

    always_comb
    begin
        pix[0] = cur_reg.r;
        pix[1] = cur_reg.g;
        pix[2] = cur_reg.b;
        pix[3] = cur_reg.a;
        for (int c = 0; c < 4; c++)
        begin
            sum[c] = cur_reg.first ? {24'd0, pix[c]}
                                   : rd_data_reg[c*32 +: 32] + {24'd0, pix[c]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg     <= rd_item;
            rd_data_reg <= acc_mem[rd_item.x];
        end
        if (state_reg == ST_ACC)
        begin
            acc_mem[cur_reg.x] <= {sum[3], sum[2], sum[1], sum[0]};
            for (int c = 0; c < 4; c++)
            begin
                rem_reg[c] <= sum[c];
            end
            dvs_reg <= {cur_reg.n, 7'd0};
        end
        else if (state_reg == ST_DIV)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (rem_reg[c] >= dvs_reg)
                begin
                    rem_reg[c] <= rem_reg[c] - dvs_reg;
                    quo_reg[c] <= {quo_reg[c][6:0], 1'b1};
                end
                else
                begin
                    quo_reg[c] <= {quo_reg[c][6:0], 1'b0};
                end
            end
            dvs_reg <= dvs_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC:
                begin
                    step_reg  <= 3'd7;
                    state_reg <= cur_reg.emit ? ST_DIV : ST_IDLE;
                end
                ST_DIV:
                begin
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = (state_reg == ST_OUT);
    assign red        = quo_reg[0];
    assign green      = quo_reg[1];
    assign blue       = quo_reg[2];
    assign alpha      = quo_reg[3];
    assign last_pixel = cur_reg.last;

endmodule

FILE: hdl/box_filter_texture_downscale.sv
// top level of the power-of-two box filter texture downscaler
//
//  channel   direction  handshake               payload
//  cfg       in         cfg_write               cfg_index, cfg_data
//  pixel in  in         in_valid / in_stall     chan_a, chan_b, chan_c, chan_d
//  pixel out out        out_valid / out_stall   red, green, blue, alpha, last_pixel
//
// the front takes one pixel a cycle while the two-entry queue has room
// each queued pixel has its accumulator read as it leaves the queue, then updated in the accumulate state
// a block's last pixel then passes through the divide state, which forms all eight quotient bits, and the output state
// dropped pixels outside the covered blocks never reach the queue
// reset clears position and factor and sets the configuration to its defaults; accumulators need no clearing
module box_filter_texture_downscale
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [bfd_pkg::IDX_W-1:0] cfg_index,
    input  logic [bfd_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                chan_a,
    input  logic [7:0]                chan_b,
    input  logic [7:0]                chan_c,
    input  logic [7:0]                chan_d,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue,
    output logic [7:0]                alpha,
    output logic                      last_pixel
);

    // classified pixel from the front and queue head for the back
    bfd_pkg::item_t wr_item;
    bfd_pkg::item_t rd_item;
    logic           push;
    logic           pop;
    logic           full;
    logic           not_empty;

    bfd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .chan_a    (chan_a),
        .chan_b    (chan_b),
        .chan_c    (chan_c),
        .chan_d    (chan_d),
        .full      (full),
        .push      (push),
        .item      (wr_item)
    );

    // short queue so the front keeps taking pixels during a divide until the queue is full
    bfd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_item   (wr_item),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_item   (rd_item)
    );

    bfd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .rd_item    (rd_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .last_pixel (last_pixel)
    );

endmodule
